### design/frlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlf_pkg
// Shared types, codes and the microcode program of the rectangle fill and
// line draw engine.
// ----------------------------------------------------------------------------
package frlf_pkg;

    localparam int FUNC_W     = 3;
    localparam int COORD_W    = 10;
    localparam int PIXEL_W    = 16;
    localparam int FILL_W_W   = 9;
    localparam int FILL_H_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [FILL_W_W-1:0] FILL_WIDTH_RESET  = 9'd256;
    localparam logic [FILL_H_W-1:0] FILL_HEIGHT_RESET = 8'd192;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_HEIGHT = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_FILL_SCREEN = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL_RECT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HLINE       = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_VLINE       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_OUTLINE     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ        = 3'd5;

    typedef logic [3:0] step_t;

    localparam step_t STEP_DONE       = 4'd0;
    localparam step_t STEP_FILL       = 4'd1;
    localparam step_t STEP_RECT       = 4'd2;
    localparam step_t STEP_HLINE      = 4'd3;
    localparam step_t STEP_VLINE      = 4'd4;
    localparam step_t STEP_OUT_LEFT   = 4'd5;
    localparam step_t STEP_OUT_RIGHT  = 4'd6;
    localparam step_t STEP_OUT_TOP    = 4'd7;
    localparam step_t STEP_OUT_BOTTOM = 4'd8;
    localparam step_t STEP_READ       = 4'd9;

    typedef enum logic [1:0] {
        UOP_DONE   = 2'd0,
        UOP_LINEAR = 2'd1,
        UOP_SPAN   = 2'd2,
        UOP_READ   = 2'd3
    } uop_t;

    typedef enum logic [1:0] {
        COND_NONE    = 2'd0,
        COND_REJECT  = 2'd1,
        COND_OUTLINE = 2'd2
    } cond_t;

    typedef enum logic {
        SEL_A = 1'b0,
        SEL_B = 1'b1
    } coord_sel_t;

    typedef enum logic [1:0] {
        END_B  = 2'd0,
        END_A1 = 2'd1,
        END_B1 = 2'd2
    } end_sel_t;

    typedef struct packed {
        uop_t       uop;
        cond_t      cond;
        coord_sel_t row_start;
        end_sel_t   row_end;
        coord_sel_t col_start;
        end_sel_t   col_end;
        step_t      jump;
        step_t      next;
    } ucode_t;

    typedef struct packed {
        logic  load;
        step_t entry;
        logic  advance;
        logic  acc;
        logic  outline_ok;
    } seq_ctrl_t;

    typedef struct packed {
        ucode_t word;
        logic   skip;
    } seq_stat_t;

    function automatic ucode_t uc(uop_t op, cond_t c, coord_sel_t rs, end_sel_t re,
                                  coord_sel_t cs, end_sel_t ce, step_t nxt);
        ucode_t w;
        w.uop       = op;
        w.cond      = c;
        w.row_start = rs;
        w.row_end   = re;
        w.col_start = cs;
        w.col_end   = ce;
        w.jump      = STEP_DONE;
        w.next      = nxt;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        unique case (s)
            STEP_FILL:
                w = uc(UOP_LINEAR, COND_NONE, SEL_A, END_B, SEL_A, END_B, STEP_DONE);
            STEP_RECT:
                w = uc(UOP_SPAN, COND_REJECT, SEL_A, END_B, SEL_A, END_B, STEP_DONE);
            STEP_HLINE:
                w = uc(UOP_SPAN, COND_REJECT, SEL_A, END_A1, SEL_A, END_B, STEP_DONE);
            STEP_VLINE:
                w = uc(UOP_SPAN, COND_REJECT, SEL_A, END_B, SEL_A, END_A1, STEP_DONE);
            STEP_OUT_LEFT:
                w = uc(UOP_SPAN, COND_OUTLINE, SEL_A, END_B, SEL_A, END_A1, STEP_OUT_RIGHT);
            STEP_OUT_RIGHT:
                w = uc(UOP_SPAN, COND_NONE, SEL_A, END_B, SEL_B, END_B1, STEP_OUT_TOP);
            STEP_OUT_TOP:
                w = uc(UOP_SPAN, COND_NONE, SEL_A, END_A1, SEL_A, END_B, STEP_OUT_BOTTOM);
            STEP_OUT_BOTTOM:
                w = uc(UOP_SPAN, COND_NONE, SEL_B, END_B1, SEL_A, END_B, STEP_DONE);
            STEP_READ:
                w = uc(UOP_READ, COND_REJECT, SEL_A, END_B, SEL_A, END_B, STEP_DONE);
            default:
                w = uc(UOP_DONE, COND_NONE, SEL_A, END_B, SEL_A, END_B, STEP_DONE);
        endcase
        return w;
    endfunction

    function automatic step_t entry_step(logic [FUNC_W-1:0] f);
        step_t s;
        unique case (f)
            FUNC_FILL_SCREEN: s = STEP_FILL;
            FUNC_FILL_RECT:   s = STEP_RECT;
            FUNC_HLINE:       s = STEP_HLINE;
            FUNC_VLINE:       s = STEP_VLINE;
            FUNC_OUTLINE:     s = STEP_OUT_LEFT;
            FUNC_READ:        s = STEP_READ;
            default:          s = STEP_DONE;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### design/frlf_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlf_cmd_if
// Command channel of the drawing engine.
// ----------------------------------------------------------------------------
interface frlf_cmd_if
    import frlf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic                      use_main;
    logic signed [COORD_W-1:0] row_a;
    logic signed [COORD_W-1:0] row_b;
    logic signed [COORD_W-1:0] col_a;
    logic signed [COORD_W-1:0] col_b;
    logic [PIXEL_W-1:0]        color;

    modport source (
        output valid, func, use_main, row_a, row_b, col_a, col_b, color,
        input  ready
    );

    modport sink (
        input  valid, func, use_main, row_a, row_b, col_a, col_b, color,
        output ready
    );
endinterface
`default_nettype wire

### design/frlf_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlf_res_if
// Result channel of the drawing engine.
// ----------------------------------------------------------------------------
interface frlf_res_if
    import frlf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] read_pixel;
    logic               accepted;

    modport source (
        output valid, read_pixel, accepted,
        input  ready
    );

    modport sink (
        input  valid, read_pixel, accepted,
        output ready
    );
endinterface
`default_nettype wire

### design/frlf_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frlf_useq
// Microcode sequencer: step counter, program ROM and conditional jump.
// ----------------------------------------------------------------------------
module frlf_useq
    import frlf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire seq_ctrl_t ctrl,
    output seq_stat_t      stat
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   skip;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        case (word.cond)
            COND_REJECT:  skip = !ctrl.acc;
            COND_OUTLINE: skip = !ctrl.acc || !ctrl.outline_ok;
            default:      skip = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (ctrl.load)
        begin
            step_next = ctrl.entry;
        end
        else if (ctrl.advance)
        begin
            step_next = skip ? word.jump : word.next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_DONE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign stat.word = word;
    assign stat.skip = skip;

endmodule
`default_nettype wire

### design/framebuffer_rect_line_fill.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_rect_line_fill
// Drawing engine over a row-major frame store: screen fill, rectangle fill,
// lines, rectangle outline and single pixel read, run by a microcode program.
// ----------------------------------------------------------------------------
// Reset clears all SCREEN_WIDTH*SCREEN_HEIGHT entries of the frame store
// (49152 by default) with cmd.ready low; configuration writes are taken at once.
// One pixel is written per cycle through the single write port of the store.
// Screen fill writes fill_width*fill_height pixels (saturated to the store size)
// from address zero; spans are written row by row. A read registers the address,
// then the store data. Rejected or degenerate commands, the other buffer and unused
// codes return a result without drawing. One command is in work at a time.
// ----------------------------------------------------------------------------
module framebuffer_rect_line_fill
    import frlf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 192
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    frlf_cmd_if.sink                   cmd,
    frlf_res_if.source                 res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW = $clog2(STORE_SIZE);
    localparam int NW = $clog2(STORE_SIZE + 1);
    localparam int RW = $clog2(SCREEN_HEIGHT + 1);
    localparam int CW = $clog2(SCREEN_WIDTH + 1);
    localparam int MW = AW + 1;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_LINEAR = 7'b0001000,
        S_SPAN   = 7'b0010000,
        S_RADDR  = 7'b0100000,
        S_RDATA  = 7'b1000000
    } state_t;

    function automatic logic row_ok(logic signed [COORD_W-1:0] v);
        return !v[COORD_W-1] && (int'(v) <= SCREEN_HEIGHT - 1);
    endfunction

    function automatic logic col_ok(logic signed [COORD_W-1:0] v);
        return !v[COORD_W-1] && (int'(v) <= SCREEN_WIDTH - 1);
    endfunction

    state_t state_reg, state_next;

    logic [FILL_W_W-1:0] fill_width_reg;
    logic [FILL_H_W-1:0] fill_height_reg;

    logic signed [COORD_W-1:0] ra_reg, ra_next;
    logic signed [COORD_W-1:0] rb_reg, rb_next;
    logic signed [COORD_W-1:0] ca_reg, ca_next;
    logic signed [COORD_W-1:0] cb_reg, cb_next;
    logic [PIXEL_W-1:0]        color_reg, color_next;
    logic                      acc_reg, acc_next;
    logic                      outline_ok_reg, outline_ok_next;
    logic [PIXEL_W-1:0]        pix_reg, pix_next;

    logic [NW-1:0] lin_cnt_reg, lin_cnt_next;
    logic [NW-1:0] lin_end_reg, lin_end_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [RW-1:0] row_end_reg, row_end_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [CW-1:0] col_start_reg, col_start_next;
    logic [CW-1:0] col_end_reg, col_end_next;

    logic               wr_en_reg, wr_en_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic [PIXEL_W-1:0] wr_data_reg, wr_data_next;
    logic [AW-1:0]      rd_addr_reg, rd_addr_next;
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [PIXEL_W-1:0] frame_mem [STORE_SIZE];

    logic               res_valid_reg, res_valid_next;
    logic [PIXEL_W-1:0] res_pixel_reg, res_pixel_next;
    logic               res_acc_reg, res_acc_next;

    seq_ctrl_t seq_ctrl;
    seq_stat_t seq_stat;
    ucode_t    word;

    logic          cmd_xfer;
    logic          cmd_acc;
    logic [RW-1:0] ra_u, rb_u, rs_v, re_v, addr_row;
    logic [CW-1:0] ca_u, cb_u, cs_v, ce_v, addr_col;
    logic          span_empty;
    logic          col_last, row_last, lin_last, clear_last;
    logic [MW-1:0] addr_full;
    logic [16:0]   fill_prod;
    logic [NW-1:0] fill_n;

    frlf_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (seq_ctrl),
        .stat  (seq_stat)
    );

    assign word      = seq_stat.word;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;

    assign res.valid      = res_valid_reg;
    assign res.read_pixel = res_pixel_reg;
    assign res.accepted   = res_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_width_reg  <= FILL_WIDTH_RESET;
            fill_height_reg <= FILL_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILL_WIDTH:  fill_width_reg  <= cfg_data;
                CFG_FILL_HEIGHT: fill_height_reg <= cfg_data[FILL_H_W-1:0];
                default:         fill_width_reg  <= fill_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.func)
            FUNC_FILL_SCREEN:
                cmd_acc = 1'b1;
            FUNC_FILL_RECT, FUNC_OUTLINE:
                cmd_acc = row_ok(cmd.row_a) && row_ok(cmd.row_b)
                          && col_ok(cmd.col_a) && col_ok(cmd.col_b);
            FUNC_HLINE:
                cmd_acc = row_ok(cmd.row_a) && col_ok(cmd.col_a) && col_ok(cmd.col_b);
            FUNC_VLINE:
                cmd_acc = row_ok(cmd.row_a) && row_ok(cmd.row_b) && col_ok(cmd.col_a);
            FUNC_READ:
                cmd_acc = row_ok(cmd.row_a) && col_ok(cmd.col_a);
            default:
                cmd_acc = 1'b0;
        endcase
    end

    assign ra_u = RW'($unsigned(ra_reg));
    assign rb_u = RW'($unsigned(rb_reg));
    assign ca_u = CW'($unsigned(ca_reg));
    assign cb_u = CW'($unsigned(cb_reg));

    always_comb
    begin
        rs_v = (word.row_start == SEL_A) ? ra_u : rb_u;
        cs_v = (word.col_start == SEL_A) ? ca_u : cb_u;
        case (word.row_end)
            END_A1:  re_v = ra_u + RW'(1);
            END_B1:  re_v = rb_u + RW'(1);
            default: re_v = rb_u;
        endcase
        case (word.col_end)
            END_A1:  ce_v = ca_u + CW'(1);
            END_B1:  ce_v = cb_u + CW'(1);
            default: ce_v = cb_u;
        endcase
    end

    assign span_empty = !((rs_v < re_v) && (cs_v < ce_v));

    assign addr_row  = (state_reg == S_SPAN) ? row_cnt_reg : ra_u;
    assign addr_col  = (state_reg == S_SPAN) ? col_cnt_reg : ca_u;
    assign addr_full = MW'(addr_row) * MW'(SCREEN_WIDTH) + MW'(addr_col);

    assign fill_prod = 17'(fill_width_reg) * 17'(fill_height_reg);
    assign fill_n    = (32'(fill_prod) > 32'(STORE_SIZE)) ? NW'(STORE_SIZE) : NW'(fill_prod);

    assign col_last   = (CW'(col_cnt_reg + CW'(1)) == col_end_reg);
    assign row_last   = (RW'(row_cnt_reg + RW'(1)) == row_end_reg);
    assign lin_last   = (NW'(lin_cnt_reg + NW'(1)) == lin_end_reg);
    assign clear_last = (lin_cnt_reg == NW'(STORE_SIZE - 1));

    always_comb
    begin
        state_next      = state_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        color_next      = color_reg;
        acc_next        = acc_reg;
        outline_ok_next = outline_ok_reg;
        pix_next        = pix_reg;
        lin_cnt_next    = lin_cnt_reg;
        lin_end_next    = lin_end_reg;
        row_cnt_next    = row_cnt_reg;
        row_end_next    = row_end_reg;
        col_cnt_next    = col_cnt_reg;
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        wr_en_next      = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_data_next    = wr_data_reg;
        rd_addr_next    = rd_addr_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_pixel_next  = res_pixel_reg;
        res_acc_next    = res_acc_reg;
        seq_ctrl        = '0;
        seq_ctrl.acc        = acc_reg;
        seq_ctrl.outline_ok = outline_ok_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = lin_cnt_reg[AW-1:0];
                wr_data_next = '0;
                lin_cnt_next = lin_cnt_reg + NW'(1);
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    ra_next         = cmd.row_a;
                    rb_next         = cmd.row_b;
                    ca_next         = cmd.col_a;
                    cb_next         = cmd.col_b;
                    color_next      = cmd.color;
                    acc_next        = cmd.use_main && cmd_acc;
                    outline_ok_next = (cmd.row_a < cmd.row_b) && (cmd.col_a < cmd.col_b);
                    pix_next        = '0;
                    seq_ctrl.load   = 1'b1;
                    seq_ctrl.entry  = cmd.use_main ? entry_step(cmd.func) : STEP_DONE;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (seq_stat.skip)
                begin
                    seq_ctrl.advance = 1'b1;
                end
                else
                begin
                    unique case (word.uop)
                        UOP_DONE:
                        begin
                            if (!res_valid_reg || res.ready)
                            begin
                                res_valid_next = 1'b1;
                                res_pixel_next = pix_reg;
                                res_acc_next   = acc_reg;
                                state_next     = S_IDLE;
                            end
                        end
                        UOP_LINEAR:
                        begin
                            seq_ctrl.advance = (fill_n == '0);
                            lin_cnt_next     = '0;
                            lin_end_next     = fill_n;
                            if (fill_n != '0)
                            begin
                                state_next = S_LINEAR;
                            end
                        end
                        UOP_SPAN:
                        begin
                            seq_ctrl.advance = span_empty;
                            row_cnt_next     = rs_v;
                            row_end_next     = re_v;
                            col_cnt_next     = cs_v;
                            col_start_next   = cs_v;
                            col_end_next     = ce_v;
                            if (!span_empty)
                            begin
                                state_next = S_SPAN;
                            end
                        end
                        UOP_READ:
                        begin
                            rd_addr_next = addr_full[AW-1:0];
                            state_next   = S_RADDR;
                        end
                        default:
                        begin
                            state_next = S_EXEC;
                        end
                    endcase
                end
            end
            S_LINEAR:
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = lin_cnt_reg[AW-1:0];
                wr_data_next = color_reg;
                lin_cnt_next = lin_cnt_reg + NW'(1);
                if (lin_last)
                begin
                    seq_ctrl.advance = 1'b1;
                    state_next       = S_EXEC;
                end
            end
            S_SPAN:
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = addr_full[AW-1:0];
                wr_data_next = color_reg;
                if (col_last)
                begin
                    col_cnt_next = col_start_reg;
                    row_cnt_next = row_cnt_reg + RW'(1);
                    if (row_last)
                    begin
                        seq_ctrl.advance = 1'b1;
                        state_next       = S_EXEC;
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + CW'(1);
                end
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                pix_next         = rd_data_reg;
                seq_ctrl.advance = 1'b1;
                state_next       = S_EXEC;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lin_cnt_reg   <= '0;
            wr_en_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lin_cnt_reg   <= lin_cnt_next;
            wr_en_reg     <= wr_en_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        ca_reg         <= ca_next;
        cb_reg         <= cb_next;
        color_reg      <= color_next;
        outline_ok_reg <= outline_ok_next;
        pix_reg        <= pix_next;
        lin_end_reg    <= lin_end_next;
        row_cnt_reg    <= row_cnt_next;
        row_end_reg    <= row_end_next;
        col_cnt_reg    <= col_cnt_next;
        col_start_reg  <= col_start_next;
        col_end_reg    <= col_end_next;
        wr_addr_reg    <= wr_addr_next;
        wr_data_reg    <= wr_data_next;
        rd_addr_reg    <= rd_addr_next;
        res_pixel_reg  <= res_pixel_next;
        res_acc_reg    <= res_acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            frame_mem[wr_addr_reg] <= wr_data_reg;
        end
        rd_data_reg <= frame_mem[rd_addr_reg];
    end

    // The clearing pass writes zeros, one entry per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> (wr_en_reg && (wr_data_reg == '0)))
        else $error("clearing pass did not write zero");

    // A rejected command never reaches the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && !acc_reg) |=> !wr_en_reg)
        else $error("rejected command wrote the frame store");

    // Only an accepted command may return a nonzero pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.accepted) |-> (res.read_pixel == '0))
        else $error("pixel returned for a rejected command");

    // Span counters stay inside the span while it is drawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPAN) |-> ((row_cnt_reg < row_end_reg) && (col_cnt_reg < col_end_reg)))
        else $error("span counter left its span");

endmodule
`default_nettype wire
